// ===== src/assert_macros.svh =====
// assertion macros shared by the longest run tracker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define LRT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lrt check failed");

// clocked check with an extra mask condition on top of reset
`define LRT_ASSERT_IF(lbl, clk, rst_n, en, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n || !(en)) prop) \
        else $error("lrt check failed");

`endif

// ===== src/lrt_pkg.sv =====
// shared types and constants of the longest run tracker
package lrt_pkg;

    localparam int MAX_LENGTH_DEF = 1024;

    localparam int SYM_W = 8;
    localparam int POS_W = 10;
    localparam int LEN_W = 11;
    localparam int RUN_W = 11;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = 1;
    localparam int Q_CW    = 2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        logic wr;    // position lies inside the active string
        logic rpt;   // update beat, a result is owed
    } t_cmd_flags;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_back_state;

endpackage

// ===== src/lrt_front.sv =====
// front end: length register, beat classification and command queue
`include "assert_macros.svh"

module lrt_front
    import lrt_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    localparam int LW = $clog2(MAX_LENGTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [POS_W-1:0]  i_position,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_clearing,
    output logic [LW-1:0]     o_eff_len,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output t_cmd_flags        o_q_flags,
    output logic [AW-1:0]     o_q_addr,
    output logic [SYM_W-1:0]  o_q_sym
);

    localparam int EW = (LW > LEN_W) ? LW : LEN_W;
    localparam int PW = (LW > POS_W) ? LW : POS_W;

    logic [LW-1:0]    r_eff_len;
    logic [LW-1:0]    n_eff_len;
    logic [EW-1:0]    cfg_ext;

    t_cmd_flags       r_q_flags [Q_DEPTH];
    logic [AW-1:0]    r_q_addr  [Q_DEPTH];
    logic [SYM_W-1:0] r_q_sym   [Q_DEPTH];
    logic [Q_PW-1:0]  r_wr_ptr;
    logic [Q_PW-1:0]  r_rd_ptr;
    logic [Q_CW-1:0]  r_count;
    logic [Q_CW-1:0]  n_count;

    logic [PW-1:0]    pos_ext;
    t_cmd_flags       in_flags;
    logic             push;
    logic             pop;

    // clamp the length once at write time
    always_comb begin
        cfg_ext = EW'(i_cfg_wdata);
        if (cfg_ext == '0) begin
            n_eff_len = LW'(1);
        end else if (cfg_ext > EW'(MAX_LENGTH)) begin
            n_eff_len = LW'(MAX_LENGTH);
        end else begin
            n_eff_len = cfg_ext[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_len <= LW'(1);
        end else if (i_cfg_we) begin
            r_eff_len <= n_eff_len;
        end
    end

    assign o_eff_len = r_eff_len;

    always_comb begin
        pos_ext      = PW'(i_position);
        in_flags.wr  = (pos_ext < PW'(r_eff_len));
        in_flags.rpt = (i_kind == KIND_UPDATE);
    end

    assign o_in_ready = (r_count != Q_CW'(Q_DEPTH)) && !i_clearing;
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign pop        = o_q_valid && i_q_ready;

    assign o_q_flags = r_q_flags[r_rd_ptr];
    assign o_q_addr  = r_q_addr[r_rd_ptr];
    assign o_q_sym   = r_q_sym[r_rd_ptr];

    always_comb begin
        case ({push, pop})
            2'b10:   n_count = r_count + Q_CW'(1);
            2'b01:   n_count = r_count - Q_CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_flags[r_wr_ptr] <= in_flags;
            r_q_addr[r_wr_ptr]  <= pos_ext[AW-1:0];
            r_q_sym[r_wr_ptr]   <= i_symbol;
        end
    end

    `LRT_ASSERT(a_q_no_overflow, i_clk, i_rst_n, r_count <= Q_CW'(Q_DEPTH))
    `LRT_ASSERT(a_q_empty_in_clear, i_clk, i_rst_n, i_clearing |-> (r_count == '0))

endmodule

// ===== src/lrt_back.sv =====
// back end: symbol memory, clearing pass, run scan and result register
`include "assert_macros.svh"

module lrt_back
    import lrt_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    localparam int LW = $clog2(MAX_LENGTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LW-1:0]     i_len,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  t_cmd_flags        i_q_flags,
    input  logic [AW-1:0]     i_q_addr,
    input  logic [SYM_W-1:0]  i_q_sym,
    output logic              o_clearing,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [RUN_W-1:0]  o_longest_run
);

    localparam int SW = (LW > RUN_W) ? LW : RUN_W;

    t_back_state      r_state;
    t_back_state      n_state;

    logic [SYM_W-1:0] r_mem [MAX_LENGTH];
    logic [SYM_W-1:0] r_rd_data;
    logic             r_rd_vld;

    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    n_clr_addr;
    logic [LW-1:0]    r_idx;
    logic [LW-1:0]    n_idx;
    logic [LW-1:0]    r_cur;
    logic [LW-1:0]    n_cur;
    logic [LW-1:0]    r_best;
    logic [LW-1:0]    n_best;
    logic [SYM_W-1:0] r_prev;
    logic [SYM_W-1:0] n_prev;

    logic             r_out_valid;
    logic [RUN_W-1:0] r_out_run;
    logic             out_load;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [SYM_W-1:0] mem_wdata;
    logic             rd_en;

    logic [SW-1:0]    best_ext;
    logic [RUN_W-1:0] run_sat;

    always_comb begin
        best_ext = SW'(r_best);
        run_sat  = (best_ext > SW'(RUN_MAX)) ? RUN_MAX : best_ext[RUN_W-1:0];
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_idx      = r_idx;
        n_cur      = r_cur;
        n_best     = r_best;
        n_prev     = r_prev;
        mem_we     = 1'b0;
        mem_waddr  = i_q_addr;
        mem_wdata  = i_q_sym;
        rd_en      = 1'b0;
        o_q_ready  = 1'b0;
        out_load   = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_LENGTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    mem_we = i_q_flags.wr;
                    if (i_q_flags.rpt) begin
                        n_idx   = '0;
                        n_cur   = '0;
                        n_best  = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = (r_idx < i_len);
                if (rd_en) begin
                    n_idx = r_idx + LW'(1);
                end
                // a zero count marks the first symbol of the string
                if (r_rd_vld) begin
                    if ((r_cur == '0) || (r_rd_data != r_prev)) begin
                        n_cur = LW'(1);
                    end else begin
                        n_cur = r_cur + LW'(1);
                    end
                    n_prev = r_rd_data;
                    n_best = (n_cur > r_best) ? n_cur : r_best;
                end
                if (!rd_en && !r_rd_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_vld   <= rd_en;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cur  <= n_cur;
        r_best <= n_best;
        r_prev <= n_prev;
        if (out_load) begin
            r_out_run <= run_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign o_clearing    = (r_state == ST_CLEAR);
    assign o_out_valid   = r_out_valid;
    assign o_longest_run = r_out_run;

    `LRT_ASSERT(a_result_from_done, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
    `LRT_ASSERT_IF(a_scan_in_bounds, i_clk, i_rst_n, r_state == ST_SCAN, r_idx <= i_len)
    `LRT_ASSERT_IF(a_best_covers_cur, i_clk, i_rst_n, r_state == ST_SCAN, r_best >= r_cur)

endmodule

// ===== src/longest_run_tracker.sv =====
// top level of the longest run tracker: front end, command queue and back end
//
//  port group    dir  handshake                    payload
//  input beat    in   i_in_valid / o_in_ready      i_kind, i_position, i_symbol
//  result beat   out  o_out_valid / i_out_ready    o_longest_run
//  length write  in   i_cfg_we                     i_cfg_wdata
//
// the back end takes a load beat in its idle state; an update beat holds it
// while it takes the beat from the queue, scans the active length through the
// single read port and its registered data, and loads the result register.
// after reset a clearing pass writes zeros over all MAX_LENGTH entries, one per
// cycle; no input beat is taken during that time, length writes are.
// a two-entry command queue and the result register let either side stall alone.

module longest_run_tracker
    import lrt_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [POS_W-1:0]  i_position,
    input  logic [SYM_W-1:0]  i_symbol,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [RUN_W-1:0]  o_longest_run,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata
);

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LW = $clog2(MAX_LENGTH + 1);

    logic [LW-1:0]    eff_len;
    logic             clearing;
    logic             q_valid;
    logic             q_ready;
    t_cmd_flags       q_flags;
    logic [AW-1:0]    q_addr;
    logic [SYM_W-1:0] q_sym;

    lrt_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .i_symbol    (i_symbol),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_clearing  (clearing),
        .o_eff_len   (eff_len),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_q_flags   (q_flags),
        .o_q_addr    (q_addr),
        .o_q_sym     (q_sym)
    );

    lrt_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_len         (eff_len),
        .i_q_valid     (q_valid),
        .o_q_ready     (q_ready),
        .i_q_flags     (q_flags),
        .i_q_addr      (q_addr),
        .i_q_sym       (q_sym),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_longest_run (o_longest_run)
    );

endmodule
